>>> rtl/wol_pkg.sv
// wavetable oscillator: shared constants, action codes and register indexes
// no dependencies; imported by the channel interfaces and the top level

package wol_pkg;

    localparam int DEF_TABLE_DEPTH  = 1024;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_FRAC_BITS    = 16;

    // fixed register widths
    localparam int INC_W     = 26;
    localparam int LEN_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = INC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC = 2'd0,
        REG_TABLE_LEN = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_START  = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

endpackage

>>> rtl/wol_if.sv
// wavetable oscillator: valid/ready channel interfaces for items and results
// depends on wol_pkg

interface wol_req_if import wol_pkg::*;
#(
    parameter int ADDR_W   = 10,
    parameter int SAMPLE_W = DEF_SAMPLE_WIDTH
) ();
    logic                       valid;
    logic                       ready;
    action_t                    action;
    logic        [ADDR_W-1:0]   table_address;
    logic signed [SAMPLE_W-1:0] table_value;

    modport source (output valid, action, table_address, table_value, input ready);
    modport sink   (input valid, action, table_address, table_value, output ready);
endinterface

interface wol_rsp_if import wol_pkg::*;
#(
    parameter int SAMPLE_W = DEF_SAMPLE_WIDTH
) ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       playing;

    modport source (output valid, sample_out, playing, input ready);
    modport sink   (input valid, sample_out, playing, output ready);
endinterface

>>> rtl/wavetable_oscillator_lerp_top.sv
// wavetable oscillator with linear interpolation: an item passes the memory read,
// multiply and sum registers before its result is offered; one item per cycle
// sustained unless a config write, a rewrap or a low rsp.ready holds the flow,
// set by the two-read-port wave memory and the single interpolation multiplier.
// a config write holds ready low while a bit-serial remainder unit rewraps phase and increment.
// reset clears phase, increment and the pipeline and restores the full table length;
// table contents stay undefined
// depends on wol_pkg and wol_if

module wavetable_oscillator_lerp_top import wol_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    wol_req_if.sink              req,
    wol_rsp_if.source            rsp
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int ULW   = $clog2(TABLE_DEPTH + 1);
    localparam int WW    = AW + FRAC_BITS;
    localparam int PH_W  = ((WW > INC_W) ? WW : INC_W) + 1;
    localparam int RIW   = PH_W - FRAC_BITS;
    localparam int CNT_W = $clog2(RIW);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int PRW   = SW + FRAC_BITS + 2;
    localparam logic signed [PRW-1:0] HALF =
        {{(PRW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // config and phase state
    logic [INC_W-1:0] inc_reg;
    logic [LEN_W-1:0] len_reg;
    logic             len_dflt_reg;
    logic [WW-1:0]    inc_mod_reg;
    logic [WW-1:0]    w_reg;
    logic [PH_W-1:0]  raw_reg;
    logic             running_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    rem_r_reg;
    logic [AW-1:0]    rem_i_reg;

    // pipeline
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 smp1_reg, smp2_reg;
    logic                 play1_reg, play2_reg, play3_reg;
    logic [FRAC_BITS-1:0] frac1_reg;
    logic signed [SW-1:0] a_rd_reg, b_rd_reg, a2_reg, sample3_reg;
    logic signed [PRW-1:0] prod2_reg;

    logic signed [SW-1:0] mem [TABLE_DEPTH];

    logic en1, en2, en3, acc, rd_en, wr_en;
    logic [ULW-1:0]            used_len;
    logic [ULW+FRAC_BITS-1:0]  period;
    logic [AW-1:0]             idx, nxt;
    logic [AW:0]               idx_inc;
    logic [FRAC_BITS-1:0]      frac;
    logic [WW:0]               wsum;
    logic [WW-1:0]             w_next;
    logic [PH_W-1:0]           raw_next;
    logic                      running_next;
    logic [RIW-1:0]            raw_int, inc_int;
    logic [AW-1:0]             rem_r_next, rem_i_next;
    logic signed [SW:0]        diff;
    logic signed [PRW-1:0]     rnd, interp_sum;

    function automatic logic [AW-1:0] rem_step(input logic [AW-1:0] rem,
                                               input logic bit_in,
                                               input logic [ULW-1:0] len);
        logic [AW:0] t;
        t = {rem, bit_in};
        if (t >= (AW+1)'(len))
            t = t - (AW+1)'(len);
        return t[AW-1:0];
    endfunction

    always_comb
    begin
        if (len_dflt_reg)
            used_len = ULW'(TABLE_DEPTH);
        else if (len_reg == '0)
            used_len = ULW'(1);
        else if (int'(len_reg) > TABLE_DEPTH)
            used_len = ULW'(TABLE_DEPTH);
        else
            used_len = ULW'(len_reg);
    end

    assign period = {used_len, {FRAC_BITS{1'b0}}};

    // handshake: each stage moves when the next one is empty or moving
    assign en3       = !v3_reg || rsp.ready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req.ready = en1 && !busy_reg && !cfg_we;
    assign acc       = req.valid && req.ready;

    assign rd_en = acc && (req.action == ACT_SAMPLE) && running_reg;
    assign wr_en = acc && (req.action == ACT_WRITE)
                   && ((AW+1)'(req.table_address) < (AW+1)'(TABLE_DEPTH));

    // w_reg holds the phase already wrapped to the current period whenever no rewrap is running
    assign frac    = w_reg[FRAC_BITS-1:0];
    assign idx     = w_reg[FRAC_BITS +: AW];
    assign idx_inc = {1'b0, idx} + (AW+1)'(1);
    assign nxt     = (idx_inc >= (AW+1)'(used_len)) ? '0 : idx_inc[AW-1:0];

    assign raw_next = PH_W'(w_reg) + PH_W'(inc_reg);
    assign wsum     = {1'b0, w_reg} + {1'b0, inc_mod_reg};
    assign w_next   = (wsum >= (WW+1)'(period)) ? WW'(wsum - (WW+1)'(period)) : wsum[WW-1:0];

    always_comb
    begin
        running_next = running_reg;
        case (req.action)
            ACT_START: running_next = 1'b1;
            ACT_STOP:  running_next = 1'b0;
            default:   running_next = running_reg;
        endcase
    end

    // bit-serial remainder of raw phase and increment by the table length
    assign raw_int    = raw_reg[PH_W-1:FRAC_BITS];
    assign inc_int    = RIW'(inc_reg[INC_W-1:FRAC_BITS]);
    assign rem_r_next = rem_step(rem_r_reg, raw_int[cnt_reg], used_len);
    assign rem_i_next = rem_step(rem_i_reg, inc_int[cnt_reg], used_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg      <= '0;
            len_reg      <= '0;
            len_dflt_reg <= 1'b1;
            inc_mod_reg  <= '0;
            w_reg        <= '0;
            raw_reg      <= '0;
            running_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            rem_r_reg    <= '0;
            rem_i_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PHASE_INC: inc_reg <= cfg_wdata[INC_W-1:0];
                    REG_TABLE_LEN:
                    begin
                        len_reg      <= cfg_wdata[LEN_W-1:0];
                        len_dflt_reg <= 1'b0;
                    end
                    default: ;
                endcase
                busy_reg  <= 1'b1;
                cnt_reg   <= CNT_W'(RIW - 1);
                rem_r_reg <= '0;
                rem_i_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_r_reg <= rem_r_next;
                rem_i_reg <= rem_i_next;
                if (cnt_reg == '0)
                begin
                    busy_reg    <= 1'b0;
                    w_reg       <= {rem_r_next, raw_reg[FRAC_BITS-1:0]};
                    inc_mod_reg <= {rem_i_next, inc_reg[FRAC_BITS-1:0]};
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
            else if (acc)
            begin
                running_reg <= running_next;
                if (req.action == ACT_STOP)
                begin
                    w_reg   <= '0;
                    raw_reg <= '0;
                end
                else if (rd_en)
                begin
                    w_reg   <= w_next;
                    raw_reg <= raw_next;
                end
            end
        end
    end

    // wave memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[req.table_address] <= req.table_value;
        if (en1 && rd_en)
        begin
            a_rd_reg <= mem[idx];
            b_rd_reg <= mem[nxt];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= acc;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // interpolation: a + round((b - a) * frac / 2^frac_bits)
    assign diff       = SW'(0) + ($signed({b_rd_reg[SW-1], b_rd_reg})
                        - $signed({a_rd_reg[SW-1], a_rd_reg}));
    assign rnd        = (prod2_reg + HALF) >>> FRAC_BITS;
    assign interp_sum = PRW'(a2_reg) + rnd;

    always_ff @(posedge clk)
    begin
        if (en1 && acc)
        begin
            smp1_reg  <= rd_en;
            frac1_reg <= frac;
            play1_reg <= running_next;
        end
        if (en2)
        begin
            smp2_reg  <= smp1_reg;
            play2_reg <= play1_reg;
            a2_reg    <= a_rd_reg;
            prod2_reg <= PRW'(diff) * PRW'($signed({1'b0, frac1_reg}));
        end
        if (en3)
        begin
            sample3_reg <= smp2_reg ? interp_sum[SW-1:0] : '0;
            play3_reg   <= play2_reg;
        end
    end

    assign rsp.valid      = v3_reg;
    assign rsp.sample_out = sample3_reg;
    assign rsp.playing    = play3_reg;

    // wrapped phase and increment stay inside one period once the rewrap is done
    a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> ((WW+1)'(w_reg) < (WW+1)'(period)))
        else $error("wrapped phase outside period");

    a_inc_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> ((WW+1)'(inc_mod_reg) < (WW+1)'(period)))
        else $error("wrapped increment outside period");

    a_busy_from_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(cfg_we))
        else $error("rewrap started without a config write");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.ready)
        else $error("item taken during rewrap");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !rsp.ready) |-> !req.ready)
        else $error("item taken with full pipeline stalled");

endmodule
